### hw/rtl/pid_position_incremental_macros.svh
// ----------------------------------------------------------------------------
// pid_position_incremental_macros
// assertion helpers used by the pid regulator top level
// ----------------------------------------------------------------------------
`ifndef PID_POSITION_INCREMENTAL_MACROS_SVH
`define PID_POSITION_INCREMENTAL_MACROS_SVH

// condition holds in the same cycle as the trigger
`define PIDPI_ASSERT_SAME(label, clk, rst_n, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error(msg);

// condition holds in the cycle after the trigger
`define PIDPI_ASSERT_NEXT(label, clk, rst_n, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

### hw/rtl/pidpi_pkg.sv
// ----------------------------------------------------------------------------
// pidpi_pkg
// types, register indexes and saturation helpers for the pid regulator
// ----------------------------------------------------------------------------
package pidpi_pkg;

    localparam int GAIN_W   = 16;
    localparam int DATA_W   = 16;
    localparam int ERR_W    = 17;
    localparam int SUM_W    = 24;
    localparam int DLIM_W   = 15;
    localparam int SLIM_W   = 23;
    localparam int ADDR_W   = 3;
    localparam int WDATA_W  = 23;
    localparam int ACC_W    = 42;
    localparam int Q_SHIFT  = 8;
    localparam int SHR_W    = ACC_W - Q_SHIFT;
    localparam int HSUM_W   = SHR_W + 1;

    // register indexes on the configuration port
    localparam logic [ADDR_W-1:0] REG_GAIN_P      = 3'd0;
    localparam logic [ADDR_W-1:0] REG_GAIN_I      = 3'd1;
    localparam logic [ADDR_W-1:0] REG_GAIN_D      = 3'd2;
    localparam logic [ADDR_W-1:0] REG_SETPOINT    = 3'd3;
    localparam logic [ADDR_W-1:0] REG_LOOP_MODE   = 3'd4;
    localparam logic [ADDR_W-1:0] REG_DRIVE_LIMIT = 3'd5;
    localparam logic [ADDR_W-1:0] REG_SUM_LIMIT   = 3'd6;

    localparam logic MODE_POSITIONAL  = 1'b0;
    localparam logic MODE_INCREMENTAL = 1'b1;

    localparam logic CMD_MEASUREMENT = 1'b0;
    localparam logic CMD_ERROR       = 1'b1;

    typedef struct packed {
        logic [GAIN_W-1:0] gain_p;
        logic [GAIN_W-1:0] gain_i;
        logic [GAIN_W-1:0] gain_d;
        logic [DATA_W-1:0] setpoint;
        logic              loop_mode;
        logic [DLIM_W-1:0] drive_limit;
        logic [SLIM_W-1:0] sum_limit;
    } cfg_t;

    // symmetric clamp of the wide drive value to +-lim
    function automatic logic signed [DATA_W-1:0] sat_drive(
        input logic signed [HSUM_W-1:0] x,
        input logic        [DLIM_W-1:0] lim
    );
        logic signed [HSUM_W-1:0] lim_s;
        logic signed [DATA_W-1:0] lim_d;
        logic signed [DATA_W-1:0] res;
        lim_s = $signed({{(HSUM_W-DLIM_W){1'b0}}, lim});
        lim_d = $signed({1'b0, lim});
        if (x > lim_s)
            res = lim_d;
        else if (x < -lim_s)
            res = -lim_d;
        else
            res = x[DATA_W-1:0];
        return res;
    endfunction

    // symmetric clamp of the integral to +-lim
    function automatic logic signed [SUM_W-1:0] sat_sum(
        input logic signed [SUM_W:0]   x,
        input logic        [SLIM_W-1:0] lim
    );
        logic signed [SUM_W:0]   lim_s;
        logic signed [SUM_W-1:0] lim_n;
        logic signed [SUM_W-1:0] res;
        lim_s = $signed({2'b00, lim});
        lim_n = $signed({1'b0, lim});
        if (x > lim_s)
            res = lim_n;
        else if (x < -lim_s)
            res = -lim_n;
        else
            res = x[SUM_W-1:0];
        return res;
    endfunction

endpackage

### hw/rtl/pidpi_cfg_regs.sv
// ----------------------------------------------------------------------------
// pidpi_cfg_regs
// configuration register file, written by index, no read-back
// ----------------------------------------------------------------------------
module pidpi_cfg_regs
    import pidpi_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [ADDR_W-1:0]  cfg_addr,
    input  logic [WDATA_W-1:0] cfg_wdata,
    output cfg_t               cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_p      <= GAIN_W'(256);
            cfg_reg.gain_i      <= '0;
            cfg_reg.gain_d      <= '0;
            cfg_reg.setpoint    <= '0;
            cfg_reg.loop_mode   <= MODE_POSITIONAL;
            cfg_reg.drive_limit <= '1;
            cfg_reg.sum_limit   <= '1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_GAIN_P:      cfg_reg.gain_p      <= cfg_wdata[GAIN_W-1:0];
                REG_GAIN_I:      cfg_reg.gain_i      <= cfg_wdata[GAIN_W-1:0];
                REG_GAIN_D:      cfg_reg.gain_d      <= cfg_wdata[GAIN_W-1:0];
                REG_SETPOINT:    cfg_reg.setpoint    <= cfg_wdata[DATA_W-1:0];
                REG_LOOP_MODE:   cfg_reg.loop_mode   <= cfg_wdata[0];
                REG_DRIVE_LIMIT: cfg_reg.drive_limit <= cfg_wdata[DLIM_W-1:0];
                REG_SUM_LIMIT:   cfg_reg.sum_limit   <= cfg_wdata[SLIM_W-1:0];
                default:         ; // unused index, write dropped
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

### hw/rtl/pidpi_datapath.sv
// ----------------------------------------------------------------------------
// pidpi_datapath
// error history, integral and held drive, with the one-pass control law
// ----------------------------------------------------------------------------
module pidpi_datapath
    import pidpi_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cfg_t                     cfg,
    input  logic                     fire,
    input  logic                     command,
    input  logic signed [DATA_W-1:0] sample,
    output logic signed [DATA_W-1:0] drive_next
);

    logic signed [ERR_W-1:0]  last_error_reg;
    logic signed [ERR_W-1:0]  older_error_reg;
    logic signed [SUM_W-1:0]  error_sum_reg;
    logic signed [DATA_W-1:0] held_drive_reg;

    logic signed [ERR_W-1:0]  err;
    logic signed [SUM_W:0]    sum_raw;
    logic signed [SUM_W-1:0]  error_sum_next;
    logic signed [ERR_W:0]    diff1;
    logic signed [ERR_W+1:0]  diff2;
    logic signed [ERR_W:0]    op_p;
    logic signed [SUM_W-1:0]  op_i;
    logic signed [ERR_W+1:0]  op_d;
    logic signed [GAIN_W+ERR_W:0]   prod_p;
    logic signed [GAIN_W+SUM_W-1:0] prod_i;
    logic signed [GAIN_W+ERR_W+1:0] prod_d;
    logic signed [ACC_W-1:0]  acc;
    logic signed [SHR_W-1:0]  acc_shr;
    logic signed [HSUM_W-1:0] held_sum;
    logic signed [HSUM_W-1:0] sat_in;
    logic                     incr;

    assign incr = (cfg.loop_mode == MODE_INCREMENTAL);

    always_comb
    begin
        if (command == CMD_ERROR)
            err = ERR_W'(sample);
        else
            err = ERR_W'($signed(cfg.setpoint)) - ERR_W'(sample);
    end

    assign sum_raw        = (SUM_W+1)'(error_sum_reg) + (SUM_W+1)'(err);
    assign error_sum_next = sat_sum(sum_raw, cfg.sum_limit);

    assign diff1 = (ERR_W+1)'(err) - (ERR_W+1)'(last_error_reg);
    assign diff2 = (ERR_W+2)'(err) - ((ERR_W+2)'(last_error_reg) <<< 1)
                 + (ERR_W+2)'(older_error_reg);

    // operands of the three gain multipliers depend on the loop form
    assign op_p = incr ? diff1 : (ERR_W+1)'(err);
    assign op_i = incr ? SUM_W'(err) : error_sum_next;
    assign op_d = incr ? diff2 : (ERR_W+2)'(diff1);

    assign prod_p = $signed(cfg.gain_p) * op_p;
    assign prod_i = $signed(cfg.gain_i) * op_i;
    assign prod_d = $signed(cfg.gain_d) * op_d;

    assign acc     = ACC_W'(prod_p) + ACC_W'(prod_i) + ACC_W'(prod_d);
    // arithmetic shift by the q8.8 fraction, floor rounding
    assign acc_shr = acc[ACC_W-1:Q_SHIFT];

    assign held_sum   = HSUM_W'(held_drive_reg) + HSUM_W'(acc_shr);
    assign sat_in     = incr ? held_sum : HSUM_W'(acc_shr);
    assign drive_next = sat_drive(sat_in, cfg.drive_limit);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_error_reg  <= '0;
            older_error_reg <= '0;
            error_sum_reg   <= '0;
            held_drive_reg  <= '0;
        end
        else if (fire)
        begin
            last_error_reg <= err;
            if (incr)
            begin
                older_error_reg <= last_error_reg;
                held_drive_reg  <= drive_next;
            end
            else
            begin
                error_sum_reg <= error_sum_next;
            end
        end
    end

endmodule

### hw/rtl/pid_position_incremental.sv
// ----------------------------------------------------------------------------
// pid_position_incremental
// pid regulator, positional or incremental form, q8.8 gains, 16-bit drive
// ----------------------------------------------------------------------------
//  port group   direction  payload
//  s_*          in         tdata: sample; tuser: command
//  m_*          out        tdata: drive
//  cfg_*        in         register write, index and data
//
//  one item per cycle sustained while results are taken; each item passes through
//  the input register, the control law runs in one pass and lands in the result
//  register; the integral and error history feed back within that pass
//  reset clears gains to their defaults and the loop state to zero
//  a stalled result holds the input register; new items still enter while
//  the input register is free or moving on
// ----------------------------------------------------------------------------
`include "pid_position_incremental_macros.svh"

module pid_position_incremental
    import pidpi_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [15:0]        s_tdata,   // [15:0] sample
    input  logic               s_tuser,   // [0] command
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [15:0]        m_tdata,   // [15:0] drive
    input  logic               cfg_we,
    input  logic [ADDR_W-1:0]  cfg_addr,
    input  logic [WDATA_W-1:0] cfg_wdata
);

    cfg_t cfg;

    logic                     in_valid_reg;
    logic                     in_cmd_reg;
    logic signed [DATA_W-1:0] in_sample_reg;
    logic                     out_valid_reg;
    logic signed [DATA_W-1:0] out_drive_reg;

    logic                     advance;
    logic                     fire;
    logic signed [DATA_W-1:0] drive_next;

    pidpi_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    pidpi_datapath u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .fire       (fire),
        .command    (in_cmd_reg),
        .sample     (in_sample_reg),
        .drive_next (drive_next)
    );

    // result register free or emptying this cycle
    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
                out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_cmd_reg    <= s_tuser;
            in_sample_reg <= $signed(s_tdata);
        end
        if (fire)
            out_drive_reg <= drive_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_drive_reg;

    `PIDPI_ASSERT_SAME(a_drive_in_limit, clk, rst_n, fire,
        (drive_next <= $signed({1'b0, cfg.drive_limit}) &&
         drive_next >= -$signed({1'b0, cfg.drive_limit})),
        "drive outside limit")

    `PIDPI_ASSERT_SAME(a_ready_when_empty, clk, rst_n, !in_valid_reg, s_tready,
        "input not ready while input register empty")

    `PIDPI_ASSERT_NEXT(a_result_follows, clk, rst_n, fire, m_tvalid,
        "processed item did not reach result register")

endmodule
